[design/bqc_pkg.sv]
`default_nettype none

package bqc_pkg;

    localparam int SIG_FRAC = 15;
    localparam int SIG_W    = 32;
    localparam int COEF_W   = 32;
    localparam int Z_W      = 48;
    localparam int PROD_W   = 64;
    localparam int MR_W     = 49;
    localparam int ACC_W    = 51;
    localparam int Y_W      = 53;
    localparam int OUT_W    = 16;
    localparam int SLOTS    = 5;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] OFF_B0 = 3'd0;
    localparam logic [2:0] OFF_B1 = 3'd1;
    localparam logic [2:0] OFF_B2 = 3'd2;
    localparam logic [2:0] OFF_A1 = 3'd3;
    localparam logic [2:0] OFF_A2 = 3'd4;

    localparam logic [2:0] ACC_HOLD    = 3'd0;
    localparam logic [2:0] ACC_LOAD_Z0 = 3'd1;
    localparam logic [2:0] ACC_LOAD_Z1 = 3'd2;
    localparam logic [2:0] ACC_LOAD    = 3'd3;
    localparam logic [2:0] ACC_SUB     = 3'd4;

    localparam logic [1:0] SEQ_NEXT = 2'd0;
    localparam logic [1:0] SEQ_LOOP = 2'd1;
    localparam logic [1:0] SEQ_END  = 2'd2;

    typedef logic [3:0] step_t;

    localparam step_t STEP_SECTION = 4'd0;
    localparam step_t STEP_END     = 4'd11;
    localparam int    UCODE_LEN    = 12;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [15:0]  sample_in;
        logic [5:0]          coef_index;
        logic signed [31:0]  coef_value;
    } bqc_in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               clipped;
    } bqc_out_t;

    typedef struct packed {
        logic       rd_en;
        logic [2:0] rd_off;
        logic       mul_y;
        logic [2:0] acc_op;
        logic       y_ld;
        logic       z0_wr;
        logic       z1_wr;
        logic       x_ld;
        logic [1:0] seq;
        step_t      target;
    } bqc_uop_t;

    // coefficient read -> product -> rounded product -> accumulator, one stage each
    function automatic bqc_uop_t bqc_ucode(input step_t step);
        bqc_uop_t u;
        u        = '0;
        u.seq    = SEQ_NEXT;
        u.acc_op = ACC_HOLD;
        case (step)
            4'd0: begin
                u.rd_en  = 1'b1;
                u.rd_off = OFF_B0;
            end
            4'd1: begin
                u.rd_en  = 1'b1;
                u.rd_off = OFF_B1;
            end
            4'd2: begin
                u.mul_y = 1'b0;
            end
            4'd3: begin
                u.acc_op = ACC_LOAD_Z0;
            end
            4'd4: begin
                u.y_ld   = 1'b1;
                u.acc_op = ACC_LOAD_Z1;
                u.rd_en  = 1'b1;
                u.rd_off = OFF_A1;
            end
            4'd5: begin
                u.rd_en  = 1'b1;
                u.rd_off = OFF_B2;
                u.mul_y  = 1'b1;
            end
            4'd6: begin
                u.rd_en  = 1'b1;
                u.rd_off = OFF_A2;
            end
            4'd7: begin
                u.mul_y  = 1'b1;
                u.acc_op = ACC_SUB;
            end
            4'd8: begin
                u.z0_wr  = 1'b1;
                u.acc_op = ACC_LOAD;
            end
            4'd9: begin
                u.acc_op = ACC_SUB;
            end
            4'd10: begin
                u.z1_wr  = 1'b1;
                u.x_ld   = 1'b1;
                u.seq    = SEQ_LOOP;
                u.target = STEP_SECTION;
            end
            default: begin
                u.seq = SEQ_END;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[design/bqc_ram.sv]
`default_nettype none

module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/biquad_cascade_iir_filter_core.sv]
`default_nettype none

// Cascade of up to MAX_SECTIONS transposed direct form II biquads in fixed point
// (Q1.15 samples, signed 32-bit coefficients with COEF_FRAC_BITS fraction bits,
// 48-bit delay state). Each s_ transaction is a sample, a coefficient write or a
// delay clear; only samples produce an m_ transaction, saturated to 16 bits with
// clipped set when saturation changed the value. cfg_data sets the number of
// active sections (reset 1, values above MAX_SECTIONS act as MAX_SECTIONS, zero
// passes samples through). A microcoded sequencer drives one shared 32x32
// multiplier fed from a coefficient RAM with separate read and write ports, five
// products per section: a sample keeps s_ready low until its result is loaded
// into the output register, which waits while it is full; coefficient writes
// and clears leave s_ready high. The output register lets the next transaction
// be accepted while a result waits. Coefficients are undefined until written.
module biquad_cascade_iir_filter_core #(
    parameter int MAX_SECTIONS   = 8,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bqc_pkg::bqc_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bqc_pkg::bqc_out_t      m_data
);

    import bqc_pkg::*;

    localparam int NUM_COEFS = SLOTS * MAX_SECTIONS;
    localparam int CA_W      = $clog2(NUM_COEFS);
    localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W     = $clog2(MAX_SECTIONS + 1);
    localparam int RSH       = COEF_FRAC_BITS - SIG_FRAC;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                     state_reg, state_next;
    step_t                    step_reg, step_next;
    logic [CNT_W-1:0]         sec_reg, sec_next;
    logic [CNT_W-1:0]         lim_reg, lim_next;
    logic [CA_W-1:0]          base_reg, base_next;
    logic [3:0]               count_reg;
    logic signed [SIG_W-1:0]  x_reg, x_next;
    logic signed [SIG_W-1:0]  y_reg, y_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MR_W-1:0]   mr_reg, mr_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [Z_W-1:0]    z0_reg [MAX_SECTIONS];
    logic signed [Z_W-1:0]    z1_reg [MAX_SECTIONS];
    logic                     m_valid_reg, m_valid_next;
    bqc_out_t                 m_data_reg, m_data_next;

    bqc_uop_t                 uop;
    logic                     run;
    logic                     s_acc;
    logic                     start;
    logic                     out_free;
    logic                     emit;
    logic [CNT_W-1:0]         sec_inc;
    logic [SEC_W-1:0]         sec_idx;
    logic signed [Z_W-1:0]    z0_rd, z1_rd;
    logic signed [Z_W-1:0]    z_sat;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [SIG_W-1:0]  mul_op;
    logic signed [Y_W-1:0]    y_wide;
    logic signed [SIG_W-1:0]  y_sat;
    logic [OUT_W-1:0]         out_sat;
    logic                     out_clip;

    logic                     ram_we;
    logic [CA_W-1:0]          ram_waddr;
    logic                     ram_re;
    logic [CA_W-1:0]          ram_raddr;
    logic [COEF_W-1:0]        ram_rdata;

    assign uop      = bqc_ucode(step_reg);
    assign run      = (state_reg == ST_RUN);
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign start    = s_acc && (s_data.req_type == REQ_SAMPLE);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = run && (uop.seq == SEQ_END) && out_free;
    assign sec_inc  = sec_reg + CNT_W'(1);
    assign sec_idx  = sec_reg[SEC_W-1:0];
    assign z0_rd    = z0_reg[sec_idx];
    assign z1_rd    = z1_reg[sec_idx];

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // coefficient store
    assign ram_we    = s_acc && (s_data.req_type == REQ_COEF)
                       && (7'(s_data.coef_index) < 7'(NUM_COEFS));
    assign ram_waddr = CA_W'(s_data.coef_index);
    assign ram_re    = run && uop.rd_en;
    assign ram_raddr = base_reg + CA_W'(uop.rd_off);

    bqc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (NUM_COEFS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.coef_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // datapath
    assign mul_op    = uop.mul_y ? y_reg : x_reg;
    assign prod_next = $signed(ram_rdata) * mul_op;
    assign prod_rnd  = prod_reg + (PROD_W'(1) <<< (SIG_FRAC - 1));
    assign mr_next   = prod_rnd[PROD_W-1:SIG_FRAC];

    always_comb begin
        acc_next = acc_reg;
        case (uop.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_LOAD_Z0: acc_next = ACC_W'(mr_reg) + ACC_W'(z0_rd);
            ACC_LOAD_Z1: acc_next = ACC_W'(mr_reg) + ACC_W'(z1_rd);
            ACC_LOAD:    acc_next = ACC_W'(mr_reg);
            ACC_SUB:     acc_next = acc_reg - ACC_W'(mr_reg);
            default:     acc_next = acc_reg;
        endcase
    end

    generate
        if (RSH > 0) begin : g_rnd_down
            assign y_wide = (Y_W'(acc_reg) + (Y_W'(1) <<< (RSH - 1))) >>> RSH;
        end else if (RSH == 0) begin : g_rnd_none
            assign y_wide = Y_W'(acc_reg);
        end else begin : g_rnd_up
            assign y_wide = Y_W'(acc_reg) <<< (-RSH);
        end
    endgenerate

    always_comb begin
        if (y_wide[Y_W-1:SIG_W-1] == {(Y_W-SIG_W+1){y_wide[Y_W-1]}}) begin
            y_sat = y_wide[SIG_W-1:0];
        end else if (y_wide[Y_W-1]) begin
            y_sat = {1'b1, {(SIG_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SIG_W-1){1'b1}}};
        end
    end

    always_comb begin
        if (acc_reg[ACC_W-1:Z_W-1] == {(ACC_W-Z_W+1){acc_reg[ACC_W-1]}}) begin
            z_sat = acc_reg[Z_W-1:0];
        end else if (acc_reg[ACC_W-1]) begin
            z_sat = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            z_sat = {1'b0, {(Z_W-1){1'b1}}};
        end
    end

    always_comb begin
        out_clip = 1'b0;
        if (x_reg[SIG_W-1:OUT_W-1] == {(SIG_W-OUT_W+1){x_reg[SIG_W-1]}}) begin
            out_sat = x_reg[OUT_W-1:0];
        end else begin
            out_clip = 1'b1;
            out_sat  = x_reg[SIG_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                      : {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign y_next = (run && uop.y_ld) ? y_sat : y_reg;

    always_comb begin
        if (count_reg > 4'(MAX_SECTIONS > 15 ? 15 : MAX_SECTIONS)) begin
            lim_next = CNT_W'(MAX_SECTIONS);
        end else begin
            lim_next = CNT_W'(count_reg);
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        sec_next     = sec_reg;
        base_next    = base_reg;
        x_next       = x_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (start) begin
            state_next = ST_RUN;
            step_next  = (lim_next == '0) ? STEP_END : STEP_SECTION;
            sec_next   = '0;
            base_next  = '0;
            x_next     = SIG_W'(s_data.sample_in);
        end else if (run) begin
            if (uop.x_ld) begin
                x_next    = y_reg;
                sec_next  = sec_inc;
                base_next = base_reg + CA_W'(SLOTS);
            end
            case (uop.seq)
                SEQ_NEXT: step_next = step_reg + 4'd1;
                SEQ_LOOP: step_next = (sec_inc != lim_reg) ? uop.target : step_reg + 4'd1;
                SEQ_END: begin
                    if (emit) begin
                        state_next             = ST_IDLE;
                        m_valid_next           = 1'b1;
                        m_data_next.sample_out = out_sat;
                        m_data_next.clipped    = out_clip;
                    end
                end
                default: step_next = step_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_SECTION;
            count_reg   <= 4'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (s_acc && (s_data.req_type == REQ_CLEAR))) begin
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                z0_reg[i] <= '0;
                z1_reg[i] <= '0;
            end
        end else if (run) begin
            if (uop.z0_wr) begin
                z0_reg[sec_idx] <= z_sat;
            end
            if (uop.z1_wr) begin
                z1_reg[sec_idx] <= z_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sec_reg    <= sec_next;
        base_reg   <= base_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        prod_reg   <= prod_next;
        mr_reg     <= mr_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        if (start) begin
            lim_reg <= lim_next;
        end
    end

`ifndef SYNTHESIS
    a_result_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RUN))
        else $error("result without a sample in flight");

    a_step_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        run |-> (step_reg < UCODE_LEN))
        else $error("step counter outside program");

    a_coef_read_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> (ram_raddr < NUM_COEFS))
        else $error("coefficient read beyond store");

    a_section_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (run && (step_reg != STEP_END)) |-> (sec_reg < lim_reg))
        else $error("section counter past active sections");
`endif

endmodule

`default_nettype wire

[dv/biquad_cascade_iir_filter_core_test.sv]
module biquad_cascade_iir_filter_core_test;
    import bqc_pkg::*;

    localparam int MAX_SEC   = 8;
    localparam int FRAC_BITS = 28;
    localparam int NUM_SLOTS = SLOTS * MAX_SEC;
    localparam int NUM_TAPS  = 2 * MAX_SEC;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // stable-ish coefficient ranges, Q4.28
    localparam int B_LIM  = 134217728;
    localparam int A1_LIM = 322122547;
    localparam int A2_LO  = 67108864;
    localparam int A2_HI  = 161061273;

    localparam int BLOCK_ITEMS = 55;
    localparam int DRAIN_WAIT  = 100;
    localparam logic [3:0] CFG_PLAN [5] = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd5};

    typedef struct {
        bit         is_cfg;
        logic [3:0] cfg;
        bqc_in_t    req;
        bit         typed;
        bqc_out_t   want;
    } script_row_t;

    logic     aclk;
    logic     aresetn;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [3:0] cfg_data;
    logic     s_valid;
    logic     s_ready;
    bqc_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    bqc_out_t m_data;

    int send_idle_pct;
    int stall_pct;
    int err_cnt;

    bqc_out_t pending_q [$];

    logic signed [31:0] coef_tab [NUM_SLOTS];
    longint             delay_tab [NUM_TAPS];
    logic [3:0]         sec_count;

    script_row_t script [28] = '{
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd0, 32'h1000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd1, 32'h0000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd2, 32'h0000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd3, 32'h0000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd4, 32'h0000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh8000, 6'd0, 32'h0}, 1'b1, '{16'sh8000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh7FFF, 6'd0, 32'h0}, 1'b1, '{16'sh7FFF, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh0000, 6'd0, 32'h0}, 1'b1, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_NONE, 16'shFFFF, 6'd63, 32'hFFFF_FFFF}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd40, 32'h7FFF_FFFF}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd63, 32'h8000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sd12345, 6'd0, 32'h0}, 1'b1, '{16'sd12345, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd0, 32'h7FFF_FFFF}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh7FFF, 6'd0, 32'h0}, 1'b1, '{16'sh7FFF, 1'b1}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh8000, 6'd0, 32'h0}, 1'b1, '{16'sh8000, 1'b1}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd0, 32'h8000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh8000, 6'd0, 32'h0}, 1'b1, '{16'sh7FFF, 1'b1}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh0001, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd1, 32'h1000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_COEF, 16'sh0000, 6'd3, 32'hF000_0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sd1000, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, -16'sd1000, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_CLEAR, 16'sh0000, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sd1000, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b1, 4'd0, '{REQ_SAMPLE, 16'sh0000, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh8000, 6'd0, 32'h0}, 1'b1, '{16'sh8000, 1'b0}},
        '{1'b0, 4'd0, '{REQ_SAMPLE, 16'sh7FFF, 6'd0, 32'h0}, 1'b1, '{16'sh7FFF, 1'b0}},
        '{1'b1, 4'd1, '{REQ_SAMPLE, 16'sh0000, 6'd0, 32'h0}, 1'b0, '{16'sh0000, 1'b0}}
    };

    biquad_cascade_iir_filter_core #(
        .MAX_SECTIONS   (MAX_SEC),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic longint rnd_shift(input longint v, input int n);
        if (n <= 0) begin
            return v <<< (-n);
        end
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input int bits, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint mul_rnd(input logic signed [31:0] c, input longint x);
        return rnd_shift(longint'(c) * x, SIG_FRAC);
    endfunction

    // updates the filter state; returns 1 when the transaction yields a result
    function automatic bit filter_request(input bqc_in_t r, output bqc_out_t res);
        longint x;
        longint acc;
        longint y;
        longint z0n;
        longint z1n;
        int     n;
        bit     hit;
        bit     spare;
        res = '0;
        hit = 1'b0;
        spare = 1'b0;
        case (r.req_type)
            REQ_COEF: begin
                if (r.coef_index < NUM_SLOTS) begin
                    coef_tab[r.coef_index] = r.coef_value;
                end
                return 1'b0;
            end
            REQ_CLEAR: begin
                foreach (delay_tab[i]) delay_tab[i] = 0;
                return 1'b0;
            end
            REQ_SAMPLE: begin
            end
            default: begin
                return 1'b0;
            end
        endcase
        x = longint'($signed(r.sample_in));
        n = (sec_count > MAX_SEC) ? MAX_SEC : int'(sec_count);
        for (int k = 0; k < n; k++) begin
            acc = mul_rnd(coef_tab[SLOTS * k + OFF_B0], x) + delay_tab[2 * k];
            y = clamp(rnd_shift(acc, FRAC_BITS - SIG_FRAC), 32, spare);
            z0n = mul_rnd(coef_tab[SLOTS * k + OFF_B1], x)
                - mul_rnd(coef_tab[SLOTS * k + OFF_A1], y) + delay_tab[2 * k + 1];
            z1n = mul_rnd(coef_tab[SLOTS * k + OFF_B2], x)
                - mul_rnd(coef_tab[SLOTS * k + OFF_A2], y);
            delay_tab[2 * k]     = clamp(z0n, 48, spare);
            delay_tab[2 * k + 1] = clamp(z1n, 48, spare);
            x = y;
        end
        x = clamp(x, 16, hit);
        res.sample_out = x[15:0];
        res.clipped = hit;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] tame_coef(input int idx);
        case (3'(idx % SLOTS))
            OFF_A1: return int'($urandom_range(2 * A1_LIM)) - A1_LIM;
            OFF_A2: return int'($urandom_range(A2_HI, A2_LO));
            default: return int'($urandom_range(2 * B_LIM)) - B_LIM;
        endcase
    endfunction

    function automatic bqc_in_t random_request();
        bqc_in_t r;
        int      pick;
        r.req_type   = REQ_SAMPLE;
        r.sample_in  = 16'($urandom);
        r.coef_index = 6'($urandom);
        r.coef_value = $urandom;
        pick = int'($urandom_range(99));
        if (pick < 70) begin
            if ($urandom_range(3) == 0) begin
                r.sample_in = 16'(int'($urandom_range(2000)) - 1000);
            end else if ($urandom_range(15) == 0) begin
                r.sample_in = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
        end else if (pick < 86) begin
            r.req_type   = REQ_COEF;
            r.coef_index = 6'($urandom_range(NUM_SLOTS - 1));
            if ($urandom_range(11) != 0) begin
                r.coef_value = tame_coef(int'(r.coef_index));
            end
        end else if (pick < 92) begin
            r.req_type = REQ_CLEAR;
        end else if (pick < 96) begin
            r.req_type = REQ_NONE;
        end else begin
            r.req_type   = REQ_COEF;
            r.coef_index = 6'($urandom_range(63, NUM_SLOTS));
        end
        return r;
    endfunction

    task automatic push_req(input bqc_in_t req, input bit typed = 1'b0,
                            input bqc_out_t want = '0);
        bqc_out_t got;
        bit       has;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        has = filter_request(req, got);
        if (has) pending_q.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    // section count changes only with nothing in flight
    task automatic write_sections(input logic [3:0] v);
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sec_count = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        bqc_out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_q.size() == 0) begin
                if (err_cnt < 40) begin
                    $display("%0t: unexpected transaction, expected none, got sample_out %0d clipped %0b",
                             $time, m_data.sample_out, m_data.clipped);
                end
                err_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (m_data.sample_out !== want.sample_out) begin
                    if (err_cnt < 40) begin
                        $display("%0t: sample_out expected %0d got %0d",
                                 $time, want.sample_out, m_data.sample_out);
                    end
                    err_cnt++;
                end
                if (m_data.clipped !== want.clipped) begin
                    if (err_cnt < 40) begin
                        $display("%0t: clipped expected %0b got %0b",
                                 $time, want.clipped, m_data.clipped);
                    end
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        bqc_in_t req;
        int      done;
        err_cnt       = 0;
        send_idle_pct = 23;
        stall_pct     = 63;
        sec_count     = 4'd1;
        foreach (coef_tab[i]) coef_tab[i] = '0;
        foreach (delay_tab[i]) delay_tab[i] = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                write_sections(script[i].cfg);
            end else begin
                push_req(script[i].req, script[i].typed, script[i].want);
            end
        end

        // fill every coefficient slot before more sections go active
        for (int i = 0; i < NUM_SLOTS; i++) begin
            req.req_type   = REQ_COEF;
            req.sample_in  = 16'($urandom);
            req.coef_index = 6'(i);
            req.coef_value = tame_coef(i);
            push_req(req);
        end

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 23;
                    stall_pct     = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    stall_pct     = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            for (int blk = 0; blk < 6; blk++) begin
                write_sections(blk < 5 ? CFG_PLAN[blk] : 4'($urandom_range(15)));
                done = 0;
                while (done < BLOCK_ITEMS) begin
                    req = random_request();
                    push_req(req);
                    if (!(req.req_type == REQ_NONE ||
                          (req.req_type == REQ_COEF && req.coef_index >= NUM_SLOTS))) begin
                        done++;
                    end
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
